// ----- design/bba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared types, field widths and status codes of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int LEVELS_DEF    = 10;
    localparam int MIN_BLOCK_DEF = 64;

    localparam int SIZE_W   = 17;
    localparam int OFFSET_W = 16;
    localparam int LEVEL_W  = 4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_BIG     = 3'd2,
        ST_NOSPACE = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef struct packed {
        logic                req_type;
        logic [SIZE_W-1:0]   request_size;
        logic [OFFSET_W-1:0] block_offset;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [OFFSET_W-1:0] granted_offset;
        logic [LEVEL_W-1:0]  granted_level;
    } t_rsp;

endpackage

// ----- design/bba_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator channels
// Valid/ready channels for requests and responses of the buddy allocator.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic          valid;
    logic          ready;
    bba_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bba_rsp_if;
    logic          valid;
    logic          ready;
    bba_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/buddy_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator with a free-node bitmap and a per-unit level record.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload
//  i_req     in   req_type, request_size, block_offset
//  o_rsp     out  status, granted_offset, granted_level
//
// After reset a clearing pass over every node address initializes both memories;
// no request is taken meanwhile. Zero-size and oversize requests respond in the next cycle.
// Allocate: probe tree nodes from the first node of the wanted level toward the root
// (up to 2^(LEVELS+1)-1 nodes), split down to the wanted level, then write the record.
// Free: the reciprocal multiply, the range check and the record lookup in turn, then
// a merge walk level by level that marks its last node free. The response holds until transferred.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int LEVELS    = bba_pkg::LEVELS_DEF,
    parameter int MIN_BLOCK = bba_pkg::MIN_BLOCK_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);

    localparam int NW    = LEVELS + 1;
    localparam int NODES = 2 << LEVELS;
    localparam int UNITS = 1 << LEVELS;
    localparam int LW    = $clog2(LEVELS + 1);
    localparam int OW    = bba_pkg::OFFSET_W;
    // Reciprocal of MIN_BLOCK, exact for every OW-bit offset.
    localparam int DSH   = OW + $clog2(MIN_BLOCK);
    localparam logic [OW+1:0] DMUL =
        (OW+2)'(((64'(1) << DSH) + 64'(MIN_BLOCK - 1)) / 64'(MIN_BLOCK));

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_SPLIT = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_RREC  = 9'b000100000,
        S_FCHK  = 9'b001000000,
        S_MRG   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic            fm [NODES];
    logic [LW:0]     rec [UNITS];
    logic            r_fm_q;
    logic [LW:0]     r_rec_q;

    logic [NW-1:0]   r_addr, n_addr;
    logic [LW-1:0]   r_lvl, n_lvl;
    logic [LW-1:0]   r_want, n_want;
    logic [NW-1:0]   r_clr;
    logic [OW-1:0]   r_quo, n_quo;
    logic [OW-1:0]   r_off, n_off;
    bba_pkg::t_rsp   r_rsp, n_rsp;

    logic            fm_we, fm_wdata;
    logic [NW-1:0]   fm_waddr, fm_raddr;
    logic            rec_we;
    logic [LEVELS-1:0] rec_waddr, rec_raddr;
    logic [LW:0]     rec_wdata;

    logic [LW-1:0]   want_c;
    logic [63:0]     region;
    logic [64:0]     size_x;
    logic [NW-1:0]   shifted;
    logic [LEVELS-1:0] alloc_unit;
    logic [2*OW+1:0] div_prod;
    logic [OW-1:0]   div_q;
    logic [31:0]     off_back;
    logic [LW-1:0]   rec_lvl;
    logic [NW-1:0]   free_node;

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = (r_state == S_DONE);
    assign o_rsp.payload = r_rsp;

    assign rec_raddr = LEVELS'(r_quo);

    // Deepest level whose block still holds the requested size.
    always_comb begin
        want_c = '0;
        size_x = 65'(i_req.payload.request_size);
        region = 64'(MIN_BLOCK) << LEVELS;
        for (int l = 0; l <= LEVELS; l++) begin
            if (size_x <= 65'(64'(MIN_BLOCK) << (LEVELS - l))) begin
                want_c = LW'(l);
            end
        end
    end

    always_comb begin
        shifted    = r_addr << (LEVELS - int'(r_want));
        alloc_unit = shifted[LEVELS-1:0];
        div_prod   = (2*OW+2)'(r_off) * (2*OW+2)'(DMUL);
        div_q      = OW'(div_prod >> DSH);
        off_back   = 32'(r_quo) * 32'(MIN_BLOCK);
        rec_lvl    = r_rec_q[LW-1:0];
        free_node  = NW'({1'b1, rec_raddr} >> (LEVELS - int'(rec_lvl)));
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_lvl     = r_lvl;
        n_want    = r_want;
        n_quo     = r_quo;
        n_off     = r_off;
        n_rsp     = r_rsp;
        fm_we     = 1'b0;
        fm_waddr  = r_addr;
        fm_wdata  = 1'b0;
        fm_raddr  = r_addr;
        rec_we    = 1'b0;
        rec_waddr = rec_raddr;
        rec_wdata = '0;

        unique case (r_state)
            S_CLEAR: begin
                fm_we     = 1'b1;
                fm_waddr  = r_clr;
                fm_wdata  = (r_clr == NW'(1));
                rec_we    = !r_clr[LEVELS];
                rec_waddr = r_clr[LEVELS-1:0];
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_rsp = '{bba_pkg::ST_OK, '0, '0};
                    if (i_req.payload.req_type == bba_pkg::REQ_FREE) begin
                        n_off   = i_req.payload.block_offset;
                        n_state = S_DIV;
                    end else if (i_req.payload.request_size == '0) begin
                        n_rsp.status = bba_pkg::ST_ZERO;
                        n_state      = S_DONE;
                    end else if (size_x > 65'(region)) begin
                        n_rsp.status = bba_pkg::ST_BIG;
                        n_state      = S_DONE;
                    end else begin
                        n_want   = want_c;
                        n_lvl    = want_c;
                        n_addr   = NW'(1) << want_c;
                        fm_raddr = n_addr;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_fm_q) begin
                    fm_we   = 1'b1;
                    n_state = S_SPLIT;
                end else if ((r_addr & (r_addr + NW'(1))) == '0) begin
                    // Last node of this level: move one level toward the root.
                    if (r_lvl == '0) begin
                        n_rsp.status = bba_pkg::ST_NOSPACE;
                        n_state      = S_DONE;
                    end else begin
                        n_lvl    = r_lvl - LW'(1);
                        n_addr   = (r_addr >> 2) + NW'(1);
                        fm_raddr = n_addr;
                    end
                end else begin
                    n_addr   = r_addr + NW'(1);
                    fm_raddr = n_addr;
                end
            end
            S_SPLIT: begin
                if (r_lvl == r_want) begin
                    rec_we       = 1'b1;
                    rec_waddr    = alloc_unit;
                    rec_wdata    = {1'b1, r_want};
                    n_rsp.status = bba_pkg::ST_OK;
                    n_rsp.granted_offset = OW'(33'(alloc_unit) * 33'(MIN_BLOCK));
                    n_rsp.granted_level  = bba_pkg::LEVEL_W'(r_want);
                    n_state      = S_DONE;
                end else begin
                    // The upper half stays free, the lower half goes on down.
                    fm_we    = 1'b1;
                    fm_waddr = {r_addr[LEVELS-1:0], 1'b1};
                    fm_wdata = 1'b1;
                    n_addr   = {r_addr[LEVELS-1:0], 1'b0};
                    n_lvl    = r_lvl + LW'(1);
                end
            end
            S_DIV: begin
                n_quo   = div_q;
                n_state = S_RREC;
            end
            S_RREC: begin
                if (off_back != 32'(r_off) || 32'(r_quo) >= 32'(UNITS)) begin
                    n_rsp.status = bba_pkg::ST_UNKNOWN;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (!r_rec_q[LW]) begin
                    n_rsp.status = bba_pkg::ST_UNKNOWN;
                    n_state      = S_DONE;
                end else begin
                    rec_we              = 1'b1;
                    n_rsp.granted_level = bba_pkg::LEVEL_W'(rec_lvl);
                    n_addr              = free_node;
                    fm_raddr            = free_node ^ NW'(1);
                    n_state             = S_MRG;
                end
            end
            S_MRG: begin
                // Walk up while the buddy is free; only the top node ends free.
                if (r_addr != NW'(1) && r_fm_q) begin
                    fm_we    = 1'b1;
                    fm_waddr = r_addr ^ NW'(1);
                    n_addr   = r_addr >> 1;
                    fm_raddr = (r_addr >> 1) ^ NW'(1);
                end else begin
                    fm_we    = 1'b1;
                    fm_wdata = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_lvl  <= n_lvl;
        r_want <= n_want;
        r_quo  <= n_quo;
        r_off  <= n_off;
        r_rsp  <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            fm[fm_waddr] <= fm_wdata;
        end
        r_fm_q <= fm[fm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec[rec_waddr] <= rec_wdata;
        end
        r_rec_q <= rec[rec_raddr];
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_rsp.status != bba_pkg::ST_OK)
            |-> (r_rsp.granted_offset == '0 && r_rsp.granted_level == '0))
        else $error("error response carries a nonzero offset or level");

    a_split_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT || r_state == S_SCAN) |-> (r_lvl <= r_want))
        else $error("search or split level passed the wanted level");

    a_merge_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRG) |-> (r_addr != '0))
        else $error("merge walked past the root");

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("new request taken in the cycle after a transfer");

endmodule
